// File: rtl/pxe_pkg.sv
// Shared types, constants and helpers of the prefix expression evaluator.
`default_nettype none

package pxe_pkg;

  // Operand width and stack geometry
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned STEP_W      = $clog2(DATA_W);
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned STACK_AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CHAR_MUL  = 8'h2A;  // '*'
  localparam logic [7:0] CHAR_DIV  = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_ADD  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SUB  = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE = 8'h39;  // '9'
  localparam logic [7:0] CHAR_UA   = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UZ   = 8'h5A;  // 'Z'
  localparam logic [7:0] CHAR_LA   = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LZ   = 8'h7A;  // 'z'

  // Value that stands in for an empty pop, a bad operator or a zero divisor
  localparam logic [DATA_W-1:0] VAL_MINUS_ONE = {DATA_W{1'b1}};

  typedef enum logic [2:0] {
    OP_MUL = 3'd0,
    OP_DIV = 3'd1,
    OP_ADD = 3'd2,
    OP_SUB = 3'd3,
    OP_BAD = 3'd4
  } op_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       final_symbol;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] value;
    logic              underflow_seen;
    logic              overflow_seen;
    logic              divide_by_zero_seen;
  } out_item_t;

  // Sequencer to arithmetic unit
  typedef struct packed {
    logic              start;
    op_e               op;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
  } alu_req_t;

  // Arithmetic unit to sequencer
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
    logic              div_zero;
  } alu_rsp_t;

  // Sequencer to operand stack
  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clear;
    logic [DATA_W-1:0] wdata;
  } stk_cmd_t;

  // Operand stack status
  typedef struct packed {
    logic [DATA_W-1:0] top;
    logic              empty;
    logic              full;
  } stk_sts_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) ||
           ((c >= CHAR_UA) && (c <= CHAR_UZ)) ||
           ((c >= CHAR_LA) && (c <= CHAR_LZ));
  endfunction

  function automatic op_e decode_op(input logic [7:0] c);
    op_e op;
    if (c == CHAR_MUL)      op = OP_MUL;
    else if (c == CHAR_DIV) op = OP_DIV;
    else if (c == CHAR_ADD) op = OP_ADD;
    else if (c == CHAR_SUB) op = OP_SUB;
    else                    op = OP_BAD;
    return op;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pxe_alu.sv
// Shared iterative arithmetic unit: shift-add multiply, restoring divide, add, subtract.
`default_nettype none

module pxe_alu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pxe_pkg::alu_req_t req_i,
  output pxe_pkg::alu_rsp_t      rsp_o
);

  typedef enum logic [3:0] {
    AL_IDLE = 4'b0001,
    AL_MUL  = 4'b0010,
    AL_DIV  = 4'b0100,
    AL_DONE = 4'b1000
  } alu_state_e;

  localparam logic [pxe_pkg::STEP_W-1:0] LAST_STEP = pxe_pkg::STEP_W'(pxe_pkg::DATA_W - 1);

  alu_state_e                    state_q, state_d;
  logic [pxe_pkg::DATA_W-1:0]    a_q, a_d;
  logic [pxe_pkg::DATA_W-1:0]    b_q, b_d;
  logic [pxe_pkg::DATA_W-1:0]    acc_q, acc_d;
  logic [pxe_pkg::STEP_W-1:0]    cnt_q, cnt_d;
  logic                          neg_q, neg_d;
  logic [pxe_pkg::DATA_W-1:0]    res_q, res_d;
  logic                          dz_q, dz_d;

  logic [pxe_pkg::DATA_W-1:0]    lhs_mag, rhs_mag;
  logic [pxe_pkg::DATA_W-1:0]    mul_sum;
  logic [pxe_pkg::DATA_W:0]      div_trial, div_diff;
  logic                          q_bit;
  logic [pxe_pkg::DATA_W-1:0]    quot;

  // Magnitudes of the signed operands (128 fits as unsigned)
  assign lhs_mag = req_i.lhs[pxe_pkg::DATA_W-1] ? (~req_i.lhs + 1'b1) : req_i.lhs;
  assign rhs_mag = req_i.rhs[pxe_pkg::DATA_W-1] ? (~req_i.rhs + 1'b1) : req_i.rhs;

  // One multiply step: add the shifted multiplicand when the multiplier bit is set
  assign mul_sum = acc_q + (b_q[0] ? a_q : '0);

  // One divide step: shift in the next dividend bit and try to subtract
  assign div_trial = {acc_q, a_q[pxe_pkg::DATA_W-1]};
  assign div_diff  = div_trial - {1'b0, b_q};
  assign q_bit     = ~div_diff[pxe_pkg::DATA_W];
  assign quot      = {a_q[pxe_pkg::DATA_W-2:0], q_bit};

  // Sequence the shared unit
  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    res_d   = res_q;
    dz_d    = dz_q;
    unique case (state_q)
      AL_IDLE: begin
        if (req_i.start) begin
          dz_d  = 1'b0;
          acc_d = '0;
          cnt_d = '0;
          unique case (req_i.op)
            pxe_pkg::OP_MUL: begin
              a_d     = req_i.lhs;
              b_d     = req_i.rhs;
              state_d = AL_MUL;
            end
            pxe_pkg::OP_DIV: begin
              if (req_i.rhs == '0) begin
                res_d   = pxe_pkg::VAL_MINUS_ONE;
                dz_d    = 1'b1;
                state_d = AL_DONE;
              end else begin
                a_d     = lhs_mag;
                b_d     = rhs_mag;
                neg_d   = req_i.lhs[pxe_pkg::DATA_W-1] ^ req_i.rhs[pxe_pkg::DATA_W-1];
                state_d = AL_DIV;
              end
            end
            pxe_pkg::OP_ADD: begin
              res_d   = req_i.lhs + req_i.rhs;
              state_d = AL_DONE;
            end
            pxe_pkg::OP_SUB: begin
              res_d   = req_i.lhs - req_i.rhs;
              state_d = AL_DONE;
            end
            default: begin
              res_d   = pxe_pkg::VAL_MINUS_ONE;
              state_d = AL_DONE;
            end
          endcase
        end
      end
      AL_MUL: begin
        acc_d = mul_sum;
        a_d   = {a_q[pxe_pkg::DATA_W-2:0], 1'b0};
        b_d   = {1'b0, b_q[pxe_pkg::DATA_W-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          res_d   = mul_sum;
          state_d = AL_DONE;
        end
      end
      AL_DIV: begin
        acc_d = q_bit ? div_diff[pxe_pkg::DATA_W-1:0] : div_trial[pxe_pkg::DATA_W-1:0];
        a_d   = quot;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          res_d   = neg_q ? (~quot + 1'b1) : quot;
          state_d = AL_DONE;
        end
      end
      AL_DONE: begin
        state_d = AL_IDLE;
      end
      default: begin
        state_d = AL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AL_IDLE;
      cnt_q   <= '0;
      dz_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dz_q    <= dz_d;
    end
  end

  // Operand and result words need no reset
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done     = (state_q == AL_DONE);
  assign rsp_o.result   = res_q;
  assign rsp_o.div_zero = dz_q;

  // Start only arrives while the unit is free
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == AL_IDLE)
    else $error("pxe_alu: start while busy");

  // The last iteration step always hands over to completion
  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == AL_MUL) || (state_q == AL_DIV)) && (cnt_q == LAST_STEP)
    |=> state_q == AL_DONE)
    else $error("pxe_alu: iteration did not finish after last step");

endmodule

`default_nettype wire

// File: rtl/pxe_stack.sv
// Operand stack: register array with a fill count, one push or pop per cycle.
`default_nettype none

module pxe_stack (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pxe_pkg::stk_cmd_t cmd_i,
  output pxe_pkg::stk_sts_t      sts_o
);

  localparam logic [pxe_pkg::CNT_W-1:0] FULL_CNT = pxe_pkg::CNT_W'(pxe_pkg::STACK_DEPTH);

  logic [pxe_pkg::DATA_W-1:0]   mem_q [pxe_pkg::STACK_DEPTH];
  logic [pxe_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [pxe_pkg::CNT_W-1:0]    top_cnt;
  logic                         empty, full;

  assign empty   = (cnt_q == '0);
  assign full    = (cnt_q == FULL_CNT);
  assign top_cnt = cnt_q - 1'b1;

  // Advance the fill count; clear empties it, drop pushes when full and pops when empty
  always_comb begin
    cnt_d = cnt_q;
    priority if (cmd_i.clear) begin
      cnt_d = '0;
    end else if (cmd_i.push && !full) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.pop && !empty) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Write the pushed word at the current fill level
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !full && !cmd_i.clear) begin
      mem_q[cnt_q[pxe_pkg::STACK_AW-1:0]] <= cmd_i.wdata;
    end
  end

  assign sts_o.top   = mem_q[top_cnt[pxe_pkg::STACK_AW-1:0]];
  assign sts_o.empty = empty;
  assign sts_o.full  = full;

  // Fill count never passes the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("pxe_stack: fill count beyond depth");

  // A push into a stack with room grows it by one
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push && !full && !cmd_i.clear |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("pxe_stack: push lost");

endmodule

`default_nettype wire

// File: rtl/prefix_expression_evaluator_unit.sv
// Top level of the prefix expression evaluator: sequencer, flags and output word.
//
// Characters of a prefix expression arrive rightmost first, one word each; the
// leftmost carries final_symbol. An alphanumeric character is accepted and then
// pushed. An operator pops two operands, starts the single shared arithmetic unit
// and pushes its result; add, subtract, an unknown code or a zero divisor need no
// iteration, while multiply and divide run the 8-step shift-add and restoring-divide
// iterations. A final character then pops the value and loads the output register,
// once any earlier result that still sits there stalled has been taken. in_stall_o
// is high for the whole time an item is at work.
`default_nettype none

module prefix_expression_evaluator_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire pxe_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output pxe_pkg::out_item_t      out_data_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_POPL  = 7'b0000010,
    S_POPR  = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_PUSH  = 7'b0100000,
    S_FINAL = 7'b1000000
  } seq_state_e;

  seq_state_e                  state_q, state_d;
  logic [7:0]                  sym_q, sym_d;
  logic                        last_q, last_d;
  logic [pxe_pkg::DATA_W-1:0]  lhs_q, lhs_d;
  logic [pxe_pkg::DATA_W-1:0]  rhs_q, rhs_d;
  logic [pxe_pkg::DATA_W-1:0]  push_q, push_d;
  logic                        under_q, under_d;
  logic                        over_q, over_d;
  logic                        div0_q, div0_d;
  logic                        out_valid_q, out_valid_d;
  pxe_pkg::out_item_t          out_q, out_d;

  pxe_pkg::alu_req_t           alu_req;
  pxe_pkg::alu_rsp_t           alu_rsp;
  pxe_pkg::stk_cmd_t           stk_cmd;
  pxe_pkg::stk_sts_t           stk_sts;

  logic                        in_accept;
  logic                        out_free;
  logic [pxe_pkg::DATA_W-1:0]  pop_val;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign pop_val   = stk_sts.empty ? pxe_pkg::VAL_MINUS_ONE : stk_sts.top;

  pxe_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  pxe_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (stk_cmd),
    .sts_o  (stk_sts)
  );

  // Per word: push an operand, or pop, run the shared unit, push; emit on the last
  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    last_d      = last_q;
    lhs_d       = lhs_q;
    rhs_d       = rhs_q;
    push_d      = push_q;
    under_d     = under_q;
    over_d      = over_q;
    div0_d      = div0_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    alu_req     = '{start: 1'b0, op: pxe_pkg::decode_op(sym_q), lhs: lhs_q, rhs: rhs_q};
    stk_cmd     = '{push: 1'b0, pop: 1'b0, clear: 1'b0, wdata: push_q};
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          sym_d  = in_data_i.symbol;
          last_d = in_data_i.final_symbol;
          push_d = in_data_i.symbol - pxe_pkg::CHAR_ZERO;
          if (pxe_pkg::is_alnum(in_data_i.symbol)) begin
            state_d = S_PUSH;
          end else begin
            state_d = S_POPL;
          end
        end
      end
      S_POPL: begin
        lhs_d       = pop_val;
        under_d     = under_q | stk_sts.empty;
        stk_cmd.pop = 1'b1;
        state_d     = S_POPR;
      end
      S_POPR: begin
        rhs_d       = pop_val;
        under_d     = under_q | stk_sts.empty;
        stk_cmd.pop = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        alu_req.start = 1'b1;
        state_d       = S_WAIT;
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          push_d  = alu_rsp.result;
          div0_d  = div0_q | alu_rsp.div_zero;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        stk_cmd.push = 1'b1;
        over_d       = over_q | stk_sts.full;
        state_d      = last_q ? S_FINAL : S_IDLE;
      end
      S_FINAL: begin
        // Hold until the output register is free, then pop, emit and clear
        if (out_free) begin
          out_d.value               = pop_val;
          out_d.underflow_seen      = under_q | stk_sts.empty;
          out_d.overflow_seen       = over_q;
          out_d.divide_by_zero_seen = div0_q;
          out_valid_d               = 1'b1;
          stk_cmd.clear             = 1'b1;
          under_d                   = 1'b0;
          over_d                    = 1'b0;
          div0_d                    = 1'b0;
          state_d                   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= 1'b0;
      under_q     <= 1'b0;
      over_q      <= 1'b0;
      div0_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      under_q     <= under_d;
      over_q      <= over_d;
      div0_q      <= div0_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload words need no reset
  always_ff @(posedge clk_i) begin
    sym_q  <= sym_d;
    lhs_q  <= lhs_d;
    rhs_q  <= rhs_d;
    push_q <= push_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Emitting a result leaves an empty stack and clear flags
  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL) && out_free
    |=> stk_sts.empty && !under_q && !over_q && !div0_q && out_valid_q)
    else $error("evaluator: state not cleared after emission");

  // A completed operation is pushed on the next cycle
  a_done_to_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) && alu_rsp.done |=> state_q == S_PUSH)
    else $error("evaluator: arithmetic result not pushed");

  // A pending result is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && (state_q == S_FINAL) |=> state_q == S_FINAL)
    else $error("evaluator: stalled result overwritten");

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Testbench of the prefix expression evaluator: directed and random expressions, scoreboard.
`timescale 1ns / 1ps

module tb;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned SHOWN_MISMATCH  = 10;
  localparam int unsigned PHASE_WORDS     = 215;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  pxe_pkg::in_item_t   in_data_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  pxe_pkg::out_item_t  out_data_o;

  // Evaluator copy: operand stack, live depth and sticky flags
  logic [7:0]  operand_copy [pxe_pkg::STACK_DEPTH];
  int unsigned live_count = 0;
  logic        seen_under = 1'b0;
  logic        seen_over  = 1'b0;
  logic        seen_div0  = 1'b0;

  pxe_pkg::out_item_t expected_results [$];
  pxe_pkg::in_item_t  expr_words [$];

  int unsigned words_sent     = 0;
  int unsigned fail_count     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  prefix_expression_evaluator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- evaluator copy

  function automatic bit is_operand_char(logic [7:0] c);
    return c inside {[pxe_pkg::CHAR_ZERO:pxe_pkg::CHAR_NINE],
                     [pxe_pkg::CHAR_UA:pxe_pkg::CHAR_UZ],
                     [pxe_pkg::CHAR_LA:pxe_pkg::CHAR_LZ]};
  endfunction

  function automatic void push_operand(logic [7:0] v);
    if (live_count >= pxe_pkg::STACK_DEPTH) begin
      seen_over = 1'b1;
    end else begin
      operand_copy[live_count] = v;
      live_count++;
    end
  endfunction

  function automatic logic [7:0] pop_operand();
    if (live_count == 0) begin
      seen_under = 1'b1;
      return pxe_pkg::VAL_MINUS_ONE;
    end
    live_count--;
    return operand_copy[live_count];
  endfunction

  function automatic logic [7:0] combine(logic [7:0] lhs, logic [7:0] rhs,
                                         logic [7:0] sym);
    int a;
    int b;
    logic [7:0] res;
    a = $signed(lhs);
    b = $signed(rhs);
    case (sym)
      pxe_pkg::CHAR_MUL: res = 8'(a * b);
      pxe_pkg::CHAR_DIV: begin
        // zero divisor gives minus one and a sticky flag
        if (b == 0) begin
          seen_div0 = 1'b1;
          res = pxe_pkg::VAL_MINUS_ONE;
        end else begin
          res = 8'(a / b);
        end
      end
      pxe_pkg::CHAR_ADD: res = 8'(a + b);
      pxe_pkg::CHAR_SUB: res = 8'(a - b);
      default:           res = pxe_pkg::VAL_MINUS_ONE;
    endcase
    return res;
  endfunction

  // Advance the evaluator copy by one accepted word, queue the result on a final word
  function automatic void predict_word(pxe_pkg::in_item_t w);
    logic [7:0] lhs;
    logic [7:0] rhs;
    pxe_pkg::out_item_t r;
    if (is_operand_char(w.symbol)) begin
      push_operand(w.symbol - pxe_pkg::CHAR_ZERO);
    end else begin
      lhs = pop_operand();
      rhs = pop_operand();
      push_operand(combine(lhs, rhs, w.symbol));
    end
    if (w.final_symbol) begin
      r.value               = pop_operand();
      r.underflow_seen      = seen_under;
      r.overflow_seen       = seen_over;
      r.divide_by_zero_seen = seen_div0;
      expected_results.push_back(r);
      live_count = 0;
      seen_under = 1'b0;
      seen_over  = 1'b0;
      seen_div0  = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic void set_idle_mode(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 73;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 73;
      end
      default: begin
        send_idle_pct  = 12;
        recv_stall_pct = 12;
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_operand_char();
    int unsigned r;
    r = $urandom_range(61);
    if (r < 10) return pxe_pkg::CHAR_ZERO + 8'(r);
    if (r < 36) return pxe_pkg::CHAR_UA + 8'(r - 10);
    return pxe_pkg::CHAR_LA + 8'(r - 36);
  endfunction

  function automatic logic [7:0] rand_operator_char();
    logic [7:0] c;
    case ($urandom_range(9))
      0, 1:    c = pxe_pkg::CHAR_MUL;
      2, 3:    c = pxe_pkg::CHAR_DIV;
      4, 5:    c = pxe_pkg::CHAR_ADD;
      6, 7:    c = pxe_pkg::CHAR_SUB;
      default: begin
        // unknown operator: any code that is not alphanumeric, known operators included
        do c = 8'($urandom_range(255)); while (is_operand_char(c));
      end
    endcase
    return c;
  endfunction

  function automatic void add_word(logic [7:0] sym);
    pxe_pkg::in_item_t w;
    w.symbol       = sym;
    w.final_symbol = 1'b0;
    expr_words.push_back(w);
  endfunction

  function automatic void mark_last_final();
    foreach (expr_words[i]) expr_words[i].final_symbol = (i == expr_words.size() - 1);
  endfunction

  // Build a well-formed expression, fed right to left; operands_first stacks all operands
  function automatic void build_expression(int unsigned n_operands, bit operands_first);
    int unsigned depth;
    int unsigned ops_left;
    int unsigned operands_left;
    depth = 0;
    ops_left = n_operands - 1;
    operands_left = n_operands;
    expr_words.delete();
    while (operands_left != 0 || ops_left != 0) begin
      if (depth >= 2 && ops_left != 0 &&
          (operands_left == 0 || (!operands_first && $urandom_range(1) == 1))) begin
        add_word(rand_operator_char());
        depth--;
        ops_left--;
      end else begin
        add_word(rand_operand_char());
        depth++;
        operands_left--;
      end
    end
    mark_last_final();
  endfunction

  // Drop one word so the operand count no longer matches
  function automatic void break_expression();
    if (expr_words.size() > 1) expr_words.delete($urandom_range(expr_words.size() - 1));
    mark_last_final();
  endfunction

  function automatic void build_noise(int unsigned n_words);
    expr_words.delete();
    repeat (n_words) add_word(8'($urandom_range(255)));
    mark_last_final();
  endfunction

  // Offer one word, hold it until accepted, then update the evaluator copy
  task automatic send_word(pxe_pkg::in_item_t w);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(w);
    words_sent++;
  endtask

  task automatic send_expression();
    foreach (expr_words[i]) send_word(expr_words[i]);
  endtask

  // Feed a string in order, final mark on its last character
  task automatic send_string(string s);
    expr_words.delete();
    for (int i = 0; i < s.len(); i++) add_word(s[i]);
    mark_last_final();
    send_expression();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    pxe_pkg::in_item_t w;
    set_idle_mode(IDLE_NONE);
    // lone unknown operators on an empty stack, lowest and highest codes
    w.final_symbol = 1'b1;
    w.symbol = 8'h00;
    send_word(w);
    w.symbol = 8'hFF;
    send_word(w);
    send_string("43+");
    send_string("92-");
    // product wraps to 8 bits
    send_string("zz*");
    // zero divisor
    send_string("08/");
    // negative quotient truncates toward zero
    send_string("270-/");
    // most negative value divided by minus one wraps back to itself
    send_string("10-pp+/");
  endtask

  task automatic test_random(int unsigned n_words, idle_mode_e mode);
    int unsigned stop_at;
    int unsigned pick;
    set_idle_mode(mode);
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        build_expression($urandom_range(1, 7), 1'b0);
      end else if (pick < 78) begin
        build_expression($urandom_range(12, 20), 1'b1);
      end else if (pick < 88) begin
        build_expression($urandom_range(2, 6), 1'b0);
        break_expression();
      end else begin
        build_noise($urandom_range(1, 8));
      end
      send_expression();
    end
  endtask

  // Hold off the receiver while words keep coming, so the block stalls its input
  task automatic test_backpressure(int unsigned n_words);
    int unsigned stop_at;
    set_idle_mode(IDLE_NONE);
    hold_request = HOLD_OFF_CYCLES;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      build_expression($urandom_range(1, 4), 1'b0);
      send_expression();
    end
  endtask

  // ---------------------------------------------------------------- receiver and checker

  // Drive the output stall: long hold-off on request, else random per the idle mode
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each accepted result word with the oldest expected one
  always @(posedge clk_i) begin
    pxe_pkg::out_item_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOWN_MISMATCH)
          $display("unexpected result word: value %0d", out_data_o.value);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data_o.value !== exp_r.value ||
            out_data_o.underflow_seen !== exp_r.underflow_seen ||
            out_data_o.overflow_seen !== exp_r.overflow_seen ||
            out_data_o.divide_by_zero_seen !== exp_r.divide_by_zero_seen) begin
          fail_count++;
          if (fail_count <= SHOWN_MISMATCH)
            $display({"result mismatch: expected value %0d uf %0b of %0b dz %0b,",
                      " got value %0d uf %0b of %0b dz %0b"},
                     exp_r.value, exp_r.underflow_seen, exp_r.overflow_seen,
                     exp_r.divide_by_zero_seen, out_data_o.value, out_data_o.underflow_seen,
                     out_data_o.overflow_seen, out_data_o.divide_by_zero_seen);
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles without any accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(PHASE_WORDS, IDLE_NONE);
    test_random(PHASE_WORDS, IDLE_SENDER);
    test_random(PHASE_WORDS, IDLE_RECEIVER);
    test_random(PHASE_WORDS, IDLE_BOTH);
    test_backpressure(60);
    // drain the remaining results with the receiver always ready
    in_valid_i <= 1'b0;
    set_idle_mode(IDLE_NONE);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
